FILE: rtl/spc_pkg.sv
// Shared types for the stack permutation checker.
// Beat structs for both channels, queue status and back-end states.
// No dependencies.
package spc_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] in_value;
    logic signed [FIELD_BITS-1:0] out_value;
    logic                         last;
  } in_beat_t;

  typedef struct packed {
    logic possible;
    logic overflow;
  } out_beat_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } q_stat_t;

  typedef enum logic [1:0] {
    S_TAKE,
    S_FETCH,
    S_CMP,
    S_FIN
  } back_state_t;

endpackage

FILE: rtl/spc_front.sv
// Input side of the checker: accepts beats into a two-entry queue.
// Depends on spc_pkg for the beat and queue status types.
module spc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spc_pkg::in_beat_t in_data,
  output spc_pkg::q_stat_t  q_stat,
  input  logic              q_pop
);
  import spc_pkg::*;

  in_beat_t   ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (cnt_r != 2'd0);

  assign q_stat.valid = (cnt_r != 2'd0);
  assign q_stat.beat  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: rtl/spc_back.sv
// Back end of the checker: stack and expected-order memories, pop loop
// and verdict register. Depends on spc_pkg; fed from spc_front.
module spc_back #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spc_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output spc_pkg::out_beat_t out_data
);
  import spc_pkg::*;

  localparam int unsigned EB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [EB-1:0] stk_mem [DEPTH];
  logic [EB-1:0] exp_mem [DEPTH];
  logic [EB-1:0] stk_rd_r, exp_rd_r;

  back_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_r, out_nxt;
  logic          we;
  logic [CW-1:0] top_idx;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign top_idx   = cnt_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    we            = 1'b0;
    unique case (state_r)
      S_TAKE: begin
        if (q_stat.valid) begin
          q_pop    = 1'b1;
          last_nxt = q_stat.beat.last;
          if (ovf_r || (wr_r >= CW'(DEPTH))) begin
            ovf_nxt   = 1'b1;
            state_nxt = q_stat.beat.last ? S_FIN : S_TAKE;
          end else begin
            we        = 1'b1;
            wr_nxt    = wr_r + CW'(1);
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ((cnt_r != '0) && (rd_r < wr_r) && (stk_rd_r == exp_rd_r)) begin
          cnt_nxt   = cnt_r - CW'(1);
          rd_nxt    = rd_r + CW'(1);
          state_nxt = S_FETCH;
        end else begin
          state_nxt = last_r ? S_FIN : S_TAKE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.possible = !ovf_r && (cnt_r == '0);
          out_nxt.overflow = ovf_r;
          cnt_nxt          = '0;
          wr_nxt           = '0;
          rd_nxt           = '0;
          ovf_nxt          = 1'b0;
          state_nxt        = S_TAKE;
        end
      end
      default: state_nxt = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TAKE;
      cnt_r       <= '0;
      wr_r        <= '0;
      rd_r        <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stk_mem[cnt_r[AW-1:0]] <= q_stat.beat.in_value[EB-1:0];
      exp_mem[wr_r[AW-1:0]]  <= q_stat.beat.out_value[EB-1:0];
    end
    stk_rd_r <= stk_mem[top_idx[AW-1:0]];
    exp_rd_r <= exp_mem[rd_r[AW-1:0]];
  end

endmodule

FILE: rtl/stack_permutation_checker.sv
// Stack permutation checker: pushes each beat, then compares the stack top
// with the expected entry via registered reads in spc_back, popping on match.
// Beats wait in a two-entry queue; S_FIN registers the last beat's verdict.
// Reset clears counters, queue and overflow flag; memories keep contents.
// Depends on spc_pkg, spc_front and spc_back.
module stack_permutation_checker #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spc_pkg::out_beat_t out_data
);
  import spc_pkg::*;

  q_stat_t q_stat;
  logic    q_pop;

  spc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_pop    (q_pop)
  );

  spc_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
